// ===== rtl/ibt_pkg.sv =====
// Shared constants and status codes for the interval booking table.
`default_nettype none

package ibt_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] STATUS_BOOKED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  // One stored interval, start inclusive and end exclusive.
  typedef struct packed {
    logic [TIME_W-1:0] slot_start;
    logic [TIME_W-1:0] slot_end;
  } slot_t;

endpackage

`default_nettype wire

// ===== rtl/ibt_if.sv =====
// Request and response channel interfaces of the interval booking table.
`default_nettype none

interface ibt_req_if;
  import ibt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] req_start;
  logic [TIME_W-1:0] req_end;

  modport source (output valid, output req_start, output req_end, input ready);
  modport sink   (input valid, input req_start, input req_end, output ready);
endinterface

interface ibt_rsp_if;
  import ibt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/interval_booking_table.sv =====
// A request is checked by a scan that reads the stored intervals from the slot memory, one
// table entry per cycle; a conflict ends the scan at the first overlapping entry, and on an
// empty table no entry is read. A new request is accepted only in the idle state, once the
// previous request has left the scan and its result has been registered.
// The result register lets the next request start its scan while a result still waits.
// Reset (asynchronous, active low) empties the table at once; memory contents are not cleared.
`default_nettype none

module interval_booking_table
  import ibt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ibt_req_if.sink     req_i,
  ibt_rsp_if.source   rsp_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                hit_q, hit_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [TIME_W-1:0]   start_q, start_d;
  logic [TIME_W-1:0]   end_q, end_d;

  slot_t               slot_mem_q [TABLE_DEPTH];
  slot_t               rd_data_q;
  logic                rd_en, wr_en;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  slot_t               wr_data;

  logic                req_xfer, out_free, overlap, table_full;

  assign req_xfer   = req_i.valid & req_i.ready;
  assign out_free   = ~out_valid_q | rsp_o.ready;
  assign overlap    = rd_vld_q & (start_q < rd_data_q.slot_end)
                               & (rd_data_q.slot_start < end_q);
  assign table_full = (count_q == CNT_W'(TABLE_DEPTH));

  assign req_i.ready  = (state_q == ST_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = status_q;

  assign rd_addr = idx_q[ADDR_W-1:0];
  assign wr_addr = count_q[ADDR_W-1:0];
  assign wr_data = '{slot_start: start_q, slot_end: end_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    start_d     = start_q;
    end_d       = end_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          start_d = req_i.req_start;
          end_d   = req_i.req_end;
          idx_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Reads are pipelined: the compare runs on the entry issued in the previous cycle.
        if (overlap) begin
          hit_d = 1'b1;
        end
        if (idx_q < count_q && !hit_d) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
        end else if (!rd_vld_q || overlap) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (hit_q) begin
            status_d = STATUS_OVERLAP;
          end else if (table_full) begin
            status_d = STATUS_FULL;
          end else begin
            status_d = STATUS_BOOKED;
            wr_en    = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    start_q  <= start_d;
    end_q    <= end_d;
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= slot_mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire
